FILE: design/occ_pkg.sv
// ----------------------------------------------------------------------------
// Occupancy marker package
// Shared sizes, codes, register layout and result types of the occupancy
// marker: grid geometry, fixed-point widths and the constant divider setup.
// ----------------------------------------------------------------------------
package occ_pkg;

  // Grid geometry and range limit
  localparam int GRID_SIDE      = 800;
  localparam int CELL_MM        = 50;
  localparam int GRID_ORIGIN_MM = 20000;
  localparam int RANGE_MM       = 50000;

  // Bitmap store
  localparam int WORD_W    = 64;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int NUM_WORDS = (GRID_SIDE * GRID_SIDE + WORD_W - 1) / WORD_W;
  localparam int ADDR_W    = $clog2(NUM_WORDS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_WORDS - 1);

  // Field widths
  localparam int KIND_W    = 2;
  localparam int COORD_W   = 18;
  localparam int IDX_W     = 14;
  localparam int REG_W     = 17;
  localparam int TRIG_W    = 16;
  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 4;
  localparam int OUT_COL_W = 10;
  localparam int COUNT_W   = 20;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Transform arithmetic
  localparam int FRAC_W = 15;
  localparam int PROD_W = COORD_W + TRIG_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int XO_W   = 22;
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(2 ** (FRAC_W - 1));
  localparam logic signed [XO_W-1:0]  ORIGIN_S   = XO_W'(GRID_ORIGIN_MM);
  localparam logic signed [COORD_W:0] RANGE_POS  = (COORD_W + 1)'(RANGE_MM);
  localparam logic signed [COORD_W:0] RANGE_NEG  = (COORD_W + 1)'(-RANGE_MM);

  // Cell division by reciprocal multiply, one correction step
  localparam int GRID_SPAN = GRID_SIDE * CELL_MM;
  localparam int SPAN_W    = $clog2(GRID_SPAN);
  localparam int RECIP_SH  = SPAN_W;
  localparam int RECIP_W   = RECIP_SH + 1;
  localparam int QPROD_W   = SPAN_W + RECIP_W;
  localparam logic [RECIP_W-1:0]     RECIP_C   = RECIP_W'((2 ** RECIP_SH) / CELL_MM);
  localparam logic [SPAN_W-1:0]      CELL_C    = SPAN_W'(CELL_MM);
  localparam logic signed [XO_W-1:0] SPAN_S    = XO_W'(GRID_SPAN);
  localparam logic signed [XO_W-1:0] NEG_LIM_S = XO_W'(-CELL_MM);
  localparam int COL_W     = $clog2(GRID_SIDE);
  localparam int CELL_W    = $clog2(GRID_SIDE * GRID_SIDE);
  localparam int XF_STAGES = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_POINT = 2'd0,
    KIND_READ  = 2'd1,
    KIND_FRAME = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXCL_X_MIN    = 4'd0,
    REG_EXCL_X_MAX    = 4'd1,
    REG_EXCL_Y_MIN    = 4'd2,
    REG_EXCL_Y_MAX    = 4'd3,
    REG_Z_LOW         = 4'd4,
    REG_Z_HIGH        = 4'd5,
    REG_YAW_ROTATION  = 4'd6,
    REG_MOUNT_OFFSET  = 4'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_XFORM,
    ST_MAP,
    ST_PUSH
  } ctl_state_e;

  typedef enum logic {
    MAP_SET,
    MAP_TAKE
  } map_op_e;

  typedef struct packed {
    logic signed [REG_W-1:0]  excl_x_min;
    logic signed [REG_W-1:0]  excl_x_max;
    logic signed [REG_W-1:0]  excl_y_min;
    logic signed [REG_W-1:0]  excl_y_max;
    logic signed [REG_W-1:0]  z_low;
    logic signed [REG_W-1:0]  z_high;
    logic signed [TRIG_W-1:0] cos_q15;
    logic signed [TRIG_W-1:0] sin_q15;
    logic signed [TRIG_W-1:0] off_x;
    logic signed [TRIG_W-1:0] off_y;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    excl_x_min: REG_W'(-1000),
    excl_x_max: REG_W'(1000),
    excl_y_min: REG_W'(-1000),
    excl_y_max: REG_W'(1000),
    z_low:      REG_W'(-2000),
    z_high:     REG_W'(3000),
    cos_q15:    TRIG_W'(32767),
    sin_q15:    '0,
    off_x:      '0,
    off_y:      '0
  };

  typedef struct packed {
    logic              kept;
    logic              in_grid;
    logic [COL_W-1:0]  col;
    logic [COL_W-1:0]  row;
    logic [ADDR_W-1:0] addr;
    logic [BIT_W-1:0]  bitpos;
  } xf_res_t;

  typedef struct packed {
    map_op_e           op;
    logic [ADDR_W-1:0] addr;
    logic [BIT_W-1:0]  bitpos;
  } map_req_t;

  typedef struct packed {
    logic                 kept;
    logic                 in_grid;
    logic [OUT_COL_W-1:0] cell_col;
    logic [OUT_COL_W-1:0] cell_row;
    logic [WORD_W-1:0]    word_data;
    logic [COUNT_W-1:0]   kept_count;
  } res_t;

endpackage

FILE: design/occ_if.sv
// ----------------------------------------------------------------------------
// Occupancy marker channels
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------
interface occ_in_if import occ_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic signed [COORD_W-1:0] x_mm;
  logic signed [COORD_W-1:0] y_mm;
  logic signed [COORD_W-1:0] z_mm;
  logic [IDX_W-1:0]          word_index;

  modport source (output valid, kind, x_mm, y_mm, z_mm, word_index, input ready);
  modport sink   (input valid, kind, x_mm, y_mm, z_mm, word_index, output ready);
endinterface

interface occ_out_if import occ_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 kept;
  logic                 in_grid;
  logic [OUT_COL_W-1:0] cell_col;
  logic [OUT_COL_W-1:0] cell_row;
  logic [WORD_W-1:0]    word_data;
  logic [COUNT_W-1:0]   kept_count;

  modport source (output valid, kept, in_grid, cell_col, cell_row, word_data, kept_count,
                  input ready);
  modport sink   (input valid, kept, in_grid, cell_col, cell_row, word_data, kept_count,
                  output ready);
endinterface

interface occ_cfg_if import occ_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/occ_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write address per cycle, read-first, registered read data.
// ----------------------------------------------------------------------------
module occ_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/occ_xform.sv
// ----------------------------------------------------------------------------
// Occupancy marker point transform
// Five-stage pipe: filter and yaw products, rounding and offset, reciprocal
// divide, remainder correction, bitmap address.
// ----------------------------------------------------------------------------
module occ_xform import occ_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [COORD_W-1:0] x_i,
  input  logic signed [COORD_W-1:0] y_i,
  input  logic signed [COORD_W-1:0] z_i,
  input  cfg_t                      cfg_i,
  output logic                      done_o,
  output xf_res_t                   res_o
);

  logic [XF_STAGES-1:0] vld_q, vld_d;

  // Stage 1: filter and products
  logic signed [COORD_W-1:0] xmin, xmax, ymin, ymax, zlo, zhi;
  logic signed [TRIG_W-1:0]  cs, sn;
  logic signed [COORD_W:0]   x_w, y_w;
  logic                      in_z, outside, in_rng;
  logic signed [PROD_W-1:0]  p_cx_d, p_sy_d, p_sx_d, p_cy_d;
  logic signed [PROD_W-1:0]  p_cx_q, p_sy_q, p_sx_q, p_cy_q;
  logic                      keep1_q;

  assign xmin = COORD_W'(cfg_i.excl_x_min);
  assign xmax = COORD_W'(cfg_i.excl_x_max);
  assign ymin = COORD_W'(cfg_i.excl_y_min);
  assign ymax = COORD_W'(cfg_i.excl_y_max);
  assign zlo  = COORD_W'(cfg_i.z_low);
  assign zhi  = COORD_W'(cfg_i.z_high);
  assign cs   = cfg_i.cos_q15;
  assign sn   = cfg_i.sin_q15;
  assign x_w  = (COORD_W + 1)'(x_i);
  assign y_w  = (COORD_W + 1)'(y_i);

  assign in_z    = (zlo <= z_i) && (z_i <= zhi);
  assign outside = (x_i >= xmax) || (x_i <= xmin) || (y_i >= ymax) || (y_i <= ymin);
  assign in_rng  = (x_w <= RANGE_POS) && (x_w >= RANGE_NEG) &&
                   (y_w <= RANGE_POS) && (y_w >= RANGE_NEG);

  assign p_cx_d = cs * x_i;
  assign p_sy_d = sn * y_i;
  assign p_sx_d = sn * x_i;
  assign p_cy_d = cs * y_i;

  // Stage 2: round half up, add mount offset and grid origin
  logic signed [SUM_W-1:0] s_x, s_y;
  logic signed [XO_W-1:0]  xo_d, yo_d, xo_q, yo_q;
  logic                    keep2_q;

  assign s_x  = SUM_W'(p_cx_q) - SUM_W'(p_sy_q) + ROUND_HALF;
  assign s_y  = SUM_W'(p_sx_q) + SUM_W'(p_cy_q) + ROUND_HALF;
  assign xo_d = XO_W'($signed(s_x[SUM_W-1:FRAC_W])) + XO_W'(cfg_i.off_x) + ORIGIN_S;
  assign yo_d = XO_W'($signed(s_y[SUM_W-1:FRAC_W])) + XO_W'(cfg_i.off_y) + ORIGIN_S;

  // Stage 3: window test and reciprocal multiply; just below zero is cell 0
  logic                in_x_d, in_y_d, in_x_q, in_y_q, keep3_q;
  logic [SPAN_W-1:0]   mag_x_d, mag_y_d, mag_x_q, mag_y_q;
  logic [QPROD_W-1:0]  qp_x, qp_y;
  logic [COL_W-1:0]    q_x_q, q_y_q;

  assign in_x_d  = (xo_q > NEG_LIM_S) && (xo_q < SPAN_S);
  assign in_y_d  = (yo_q > NEG_LIM_S) && (yo_q < SPAN_S);
  assign mag_x_d = xo_q[XO_W-1] ? '0 : xo_q[SPAN_W-1:0];
  assign mag_y_d = yo_q[XO_W-1] ? '0 : yo_q[SPAN_W-1:0];
  assign qp_x    = mag_x_d * RECIP_C;
  assign qp_y    = mag_y_d * RECIP_C;

  // Stage 4: one correction step on the quotient
  logic [SPAN_W-1:0] qc_x, qc_y, rem_x, rem_y;
  logic [COL_W-1:0]  col_d, row_d, col_q, row_q;
  logic              grid_d, grid_q, keep4_q;

  assign qc_x   = SPAN_W'(q_x_q) * CELL_C;
  assign qc_y   = SPAN_W'(q_y_q) * CELL_C;
  assign rem_x  = mag_x_q - qc_x;
  assign rem_y  = mag_y_q - qc_y;
  assign grid_d = keep3_q && in_x_q && in_y_q;
  assign col_d  = !grid_d ? '0 : ((rem_x >= CELL_C) ? q_x_q + COL_W'(1) : q_x_q);
  assign row_d  = !grid_d ? '0 : ((rem_y >= CELL_C) ? q_y_q + COL_W'(1) : q_y_q);

  // Stage 5: cell number and bitmap address
  logic [CELL_W-1:0] cell_num;
  xf_res_t           res_q;

  assign cell_num = CELL_W'(row_q) * CELL_W'(GRID_SIDE) + CELL_W'(col_q);

  assign vld_d = {vld_q[XF_STAGES-2:0], start_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    keep1_q <= in_z && outside && in_rng;
    p_cx_q  <= p_cx_d;
    p_sy_q  <= p_sy_d;
    p_sx_q  <= p_sx_d;
    p_cy_q  <= p_cy_d;

    keep2_q <= keep1_q;
    xo_q    <= xo_d;
    yo_q    <= yo_d;

    keep3_q <= keep2_q;
    in_x_q  <= in_x_d;
    in_y_q  <= in_y_d;
    mag_x_q <= mag_x_d;
    mag_y_q <= mag_y_d;
    q_x_q   <= COL_W'(qp_x >> RECIP_SH);
    q_y_q   <= COL_W'(qp_y >> RECIP_SH);

    keep4_q <= keep3_q;
    grid_q  <= grid_d;
    col_q   <= col_d;
    row_q   <= row_d;

    res_q.kept    <= keep4_q;
    res_q.in_grid <= grid_q;
    res_q.col     <= col_q;
    res_q.row     <= row_q;
    res_q.addr    <= ADDR_W'(cell_num >> BIT_W);
    res_q.bitpos  <= cell_num[BIT_W-1:0];
  end

  assign done_o = vld_q[XF_STAGES-1];
  assign res_o  = res_q;

endmodule

FILE: design/occ_map.sv
// ----------------------------------------------------------------------------
// Occupancy bitmap
// Bitmap RAM with a clearing sweep after reset and a read-modify-write
// (read, then write-back) for set-bit and take-word requests.
// ----------------------------------------------------------------------------
module occ_map import occ_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  map_req_t          req_i,
  output logic              ready_o,
  output logic              rsp_valid_o,
  output logic [WORD_W-1:0] rsp_data_o
);

  logic              init_q;
  logic [ADDR_W-1:0] clr_addr_q;
  logic              pend_q;
  map_req_t          pend_req_q;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  // Requests come one at a time from the controller, so a read never
  // meets its own write-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q     <= 1'b1;
      clr_addr_q <= '0;
      pend_q     <= 1'b0;
    end else begin
      pend_q <= req_valid_i && !init_q;
      if (init_q) begin
        clr_addr_q <= clr_addr_q + ADDR_W'(1);
        if (clr_addr_q == LAST_ADDR) begin
          init_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i) begin
      pend_req_q <= req_i;
    end
  end

  always_comb begin
    ram_we    = init_q || pend_q;
    ram_addr  = init_q ? clr_addr_q : (pend_q ? pend_req_q.addr : req_i.addr);
    ram_wdata = '0;
    if (!init_q && pend_req_q.op == MAP_SET) begin
      ram_wdata = ram_rdata | (WORD_W'(1) << pend_req_q.bitpos);
    end
  end

  occ_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign ready_o     = !init_q;
  assign rsp_valid_o = pend_q;
  assign rsp_data_o  = ram_rdata;

endmodule

FILE: design/point_cloud_occupancy_marker_unit.sv
// ----------------------------------------------------------------------------
// Point cloud occupancy marker
// Path per kind: a point marked in the grid runs the transform pipe, the
// bitmap update and the push; any other point skips the bitmap; a word read
// in range takes the word and pushes; all else goes straight to the push.
// One transaction at a time: the next input is taken once the result is in
// the output register. After reset a sweep clears the bitmap, one word a
// cycle; no input is taken meanwhile, register writes always are.
// ----------------------------------------------------------------------------
module point_cloud_occupancy_marker_unit import occ_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  occ_in_if.sink    item_i,
  occ_out_if.source result_o,
  occ_cfg_if.sink   cfg_i
);

  // --------------------------------------------------------------------------
  // Configuration registers: writes land at once, no busy check.
  // --------------------------------------------------------------------------
  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        REG_EXCL_X_MIN:   cfg_q.excl_x_min <= cfg_i.data[REG_W-1:0];
        REG_EXCL_X_MAX:   cfg_q.excl_x_max <= cfg_i.data[REG_W-1:0];
        REG_EXCL_Y_MIN:   cfg_q.excl_y_min <= cfg_i.data[REG_W-1:0];
        REG_EXCL_Y_MAX:   cfg_q.excl_y_max <= cfg_i.data[REG_W-1:0];
        REG_Z_LOW:        cfg_q.z_low      <= cfg_i.data[REG_W-1:0];
        REG_Z_HIGH:       cfg_q.z_high     <= cfg_i.data[REG_W-1:0];
        REG_YAW_ROTATION: begin
          cfg_q.cos_q15 <= cfg_i.data[TRIG_W-1:0];
          cfg_q.sin_q15 <= cfg_i.data[DATA_W-1:TRIG_W];
        end
        REG_MOUNT_OFFSET: begin
          cfg_q.off_x <= cfg_i.data[TRIG_W-1:0];
          cfg_q.off_y <= cfg_i.data[DATA_W-1:TRIG_W];
        end
        default: begin
          // drop writes past the register list
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Submodules: transform pipe and bitmap store
  // --------------------------------------------------------------------------
  logic              accept;
  logic              xf_start, xf_done;
  xf_res_t           xf_res;
  logic              map_req_valid, map_ready, map_rsp_valid;
  map_req_t          map_req;
  logic [WORD_W-1:0] map_rsp_data;

  occ_xform u_xform (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (xf_start),
    .x_i     (item_i.x_mm),
    .y_i     (item_i.y_mm),
    .z_i     (item_i.z_mm),
    .cfg_i   (cfg_q),
    .done_o  (xf_done),
    .res_o   (xf_res)
  );

  occ_map u_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (map_req_valid),
    .req_i       (map_req),
    .ready_o     (map_ready),
    .rsp_valid_o (map_rsp_valid),
    .rsp_data_o  (map_rsp_data)
  );

  // --------------------------------------------------------------------------
  // Sequencer: one transaction in flight. The result is built in res_q and
  // handed to the output register, which frees the input side again.
  // --------------------------------------------------------------------------
  ctl_state_e         state_q, state_d;
  kind_e              kind_q, kind_d;
  logic [COUNT_W-1:0] count_q, count_d;
  res_t               res_q, res_d;
  res_t               out_q;
  logic               out_valid_q, out_valid_d;
  logic               push;
  logic               idx_ok;

  assign item_i.ready = (state_q == ST_IDLE) && map_ready;
  assign accept       = item_i.valid && item_i.ready;
  assign xf_start     = accept && (kind_e'(item_i.kind) == KIND_POINT);
  assign idx_ok       = 32'(item_i.word_index) < 32'(NUM_WORDS);

  always_comb begin
    state_d       = state_q;
    kind_d        = kind_q;
    count_d       = count_q;
    res_d         = res_q;
    push          = 1'b0;
    map_req_valid = 1'b0;
    map_req.op     = MAP_SET;
    map_req.addr   = xf_res.addr;
    map_req.bitpos = xf_res.bitpos;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          kind_d = kind_e'(item_i.kind);
          res_d  = '0;
          case (kind_e'(item_i.kind))
            KIND_POINT: state_d = ST_XFORM;
            KIND_READ: begin
              // Take the word: read it and write back zero.
              if (idx_ok) begin
                map_req_valid = 1'b1;
                map_req.op    = MAP_TAKE;
                map_req.addr  = ADDR_W'(item_i.word_index);
                state_d       = ST_MAP;
              end else begin
                state_d = ST_PUSH;
              end
            end
            KIND_FRAME: begin
              res_d.kept_count = count_q;
              count_d          = '0;
              state_d          = ST_PUSH;
            end
            default: state_d = ST_PUSH;
          endcase
        end
      end
      ST_XFORM: begin
        if (xf_done) begin
          res_d.kept     = xf_res.kept;
          res_d.in_grid  = xf_res.in_grid;
          res_d.cell_col = OUT_COL_W'(xf_res.col);
          res_d.cell_row = OUT_COL_W'(xf_res.row);
          if (xf_res.kept && count_q != COUNT_MAX) begin
            count_d = count_q + COUNT_W'(1);
          end
          if (xf_res.in_grid) begin
            map_req_valid = 1'b1;
            state_d       = ST_MAP;
          end else begin
            state_d = ST_PUSH;
          end
        end
      end
      ST_MAP: begin
        // Hold until the write-back cycle; only a read reports the word.
        if (map_rsp_valid) begin
          if (kind_q == KIND_READ) begin
            res_d.word_data = map_rsp_data;
          end
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!out_valid_q || result_o.ready) begin
          push    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (push) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    res_q  <= res_d;
    if (push) begin
      out_q <= res_q;
    end
  end

  // --------------------------------------------------------------------------
  // Result channel
  // --------------------------------------------------------------------------
  assign result_o.valid      = out_valid_q;
  assign result_o.kept       = out_q.kept;
  assign result_o.in_grid    = out_q.in_grid;
  assign result_o.cell_col   = out_q.cell_col;
  assign result_o.cell_row   = out_q.cell_row;
  assign result_o.word_data  = out_q.word_data;
  assign result_o.kept_count = out_q.kept_count;

endmodule

FILE: design/occ_checker.sv
// ----------------------------------------------------------------------------
// Occupancy marker port checker
// Watches the top-level channels for handshake and result consistency.
// ----------------------------------------------------------------------------
module occ_checker import occ_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic                 kept_i,
  input logic                 in_grid_i,
  input logic [OUT_COL_W-1:0] cell_col_i,
  input logic [OUT_COL_W-1:0] cell_row_i,
  input logic [WORD_W-1:0]    word_data_i,
  input logic [COUNT_W-1:0]   kept_count_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(kept_i) && $stable(in_grid_i) &&
      $stable(cell_col_i) && $stable(cell_row_i) && $stable(word_data_i) &&
      $stable(kept_count_i))
    else $error("stalled result changed");

  a_grid_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && in_grid_i |-> kept_i)
    else $error("marked point not flagged as kept");

  a_cell_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !in_grid_i |-> cell_col_i == '0 && cell_row_i == '0)
    else $error("cell reported for unmarked result");

  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while a transaction is in flight");

endmodule

bind point_cloud_occupancy_marker_unit occ_checker u_occ_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (item_i.valid),
  .in_ready_i   (item_i.ready),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .kept_i       (result_o.kept),
  .in_grid_i    (result_o.in_grid),
  .cell_col_i   (result_o.cell_col),
  .cell_row_i   (result_o.cell_row),
  .word_data_i  (result_o.word_data),
  .kept_count_i (result_o.kept_count)
);

FILE: sim/point_cloud_occupancy_marker_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Occupancy marker testbench
// Drives points, word reads and frame ends into the marker through its
// valid/ready channels. A directed table comes first, then phases of random
// traffic, each under a different register setting. A cycle-free model of
// the filter, the yaw transform, the bitmap and the frame counter predicts
// each untyped result; every result is compared field by field in order.
// ----------------------------------------------------------------------------
module point_cloud_occupancy_marker_unit_tb;
  import occ_pkg::*;

  localparam int CLK_HALF_NS  = 6;
  localparam int RESET_CYCLES = 8;
  localparam int MAX_GAP      = 8;
  // The reset sweep alone idles every channel while it clears the bitmap.
  localparam int STALL_LIMIT  = 4 * NUM_WORDS;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 185;
  localparam int BURST_SPAN   = 40;
  localparam int HOT_WORDS    = 64;

  // Kind code that the package leaves unnamed, and the first spare register.
  localparam logic [KIND_W-1:0]    KIND_UNUSED     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 4'd8;

  typedef struct {
    logic [KIND_W-1:0]         kind;
    logic signed [COORD_W-1:0] x_mm;
    logic signed [COORD_W-1:0] y_mm;
    logic signed [COORD_W-1:0] z_mm;
    logic [IDX_W-1:0]          word_index;
  } marker_item_t;

  typedef struct {
    marker_item_t item;
    bit           typed;
    res_t         result;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  occ_in_if  item_if ();
  occ_out_if res_if ();
  occ_cfg_if cfg_if ();

  point_cloud_occupancy_marker_unit u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  // Shadow state of the block: registers, bitmap and frame counter.
  cfg_t              cfg_shadow = CFG_RESET;
  logic [WORD_W-1:0] grid_shadow [NUM_WORDS];
  logic [COUNT_W-1:0] frame_kept_shadow = '0;
  int                marked_words [$];

  res_t      pending_results [$];
  stim_row_t stim_rows [$];

  // Typed expectation that travels with the item currently on the channel.
  bit   row_typed;
  res_t row_expected;

  bit no_idle    = 1'b0;
  int fail_count = 0;
  int idle_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF_NS) clk_i = ~clk_i;
  end

  initial begin
    for (int i = 0; i < NUM_WORDS; i++) grid_shadow[i] = '0;
  end

  // --------------------------------------------------------------------------
  // Predict one result and advance the shadow state.
  // --------------------------------------------------------------------------
  function automatic res_t predict_marker(input logic [KIND_W-1:0] kind,
                                          input logic signed [COORD_W-1:0] px,
                                          input logic signed [COORD_W-1:0] py,
                                          input logic signed [COORD_W-1:0] pz,
                                          input logic [IDX_W-1:0] widx);
    res_t   r;
    longint x, y, z, c, s, xr, yr, col, row, cell_num;
    bit     in_z, outside, in_range;
    r = '0;
    x = px;
    y = py;
    z = pz;
    case (kind)
      KIND_POINT: begin
        in_z = z >= longint'($signed(cfg_shadow.z_low)) &&
               z <= longint'($signed(cfg_shadow.z_high));
        outside = x >= longint'($signed(cfg_shadow.excl_x_max)) ||
                  x <= longint'($signed(cfg_shadow.excl_x_min)) ||
                  y >= longint'($signed(cfg_shadow.excl_y_max)) ||
                  y <= longint'($signed(cfg_shadow.excl_y_min));
        in_range = x <= RANGE_MM && x >= -RANGE_MM && y <= RANGE_MM && y >= -RANGE_MM;
        if (in_z && outside && in_range) begin
          c = longint'($signed(cfg_shadow.cos_q15));
          s = longint'($signed(cfg_shadow.sin_q15));
          // Round half up: bias by half an LSB, then floor with an arithmetic shift.
          xr = ((c * x - s * y + (longint'(1) << (FRAC_W - 1))) >>> FRAC_W) +
               longint'($signed(cfg_shadow.off_x));
          yr = ((s * x + c * y + (longint'(1) << (FRAC_W - 1))) >>> FRAC_W) +
               longint'($signed(cfg_shadow.off_y));
          // Division truncates toward zero, so small negatives land in cell 0.
          col = (xr + GRID_ORIGIN_MM) / CELL_MM;
          row = (yr + GRID_ORIGIN_MM) / CELL_MM;
          r.kept = 1'b1;
          if (frame_kept_shadow != COUNT_MAX) frame_kept_shadow = frame_kept_shadow + 1'b1;
          if (col >= 0 && col < GRID_SIDE && row >= 0 && row < GRID_SIDE) begin
            cell_num = row * GRID_SIDE + col;
            grid_shadow[cell_num / WORD_W][cell_num % WORD_W] = 1'b1;
            if (marked_words.size() >= HOT_WORDS) void'(marked_words.pop_front());
            marked_words.push_back(int'(cell_num / WORD_W));
            r.in_grid  = 1'b1;
            r.cell_col = OUT_COL_W'(col);
            r.cell_row = OUT_COL_W'(row);
          end
        end
      end
      KIND_READ: begin
        if (widx < NUM_WORDS) begin
          r.word_data = grid_shadow[widx];
          grid_shadow[widx] = '0;
        end
      end
      KIND_FRAME: begin
        r.kept_count = frame_kept_shadow;
        frame_kept_shadow = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int rand_between(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // Encode a 17-bit register value; now and then fill the unused upper bits
  // with noise, since the block must drop them.
  function automatic logic [DATA_W-1:0] reg_word(input int v);
    logic [DATA_W-1:0] w;
    w = DATA_W'(v);
    if ($urandom_range(0, 3) == 0) w[DATA_W-1:REG_W] = (DATA_W - REG_W)'($urandom());
    return w;
  endfunction

  task automatic add_row(input logic [KIND_W-1:0] kind, input int x, input int y,
                         input int z, input int widx, input bit typed,
                         input logic kept);
    stim_row_t row;
    row.item.kind       = kind;
    row.item.x_mm       = COORD_W'(x);
    row.item.y_mm       = COORD_W'(y);
    row.item.z_mm       = COORD_W'(z);
    row.item.word_index = IDX_W'(widx);
    row.typed           = typed;
    row.result          = '0;
    row.result.kept     = kept;
    stim_rows.push_back(row);
  endtask

  // Hold valid across back-to-back items; drop it only for a drawn gap.
  task automatic send_item(input marker_item_t it, input bit typed, input res_t exp_res);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid      <= 1'b1;
    item_if.kind       <= it.kind;
    item_if.x_mm       <= it.x_mm;
    item_if.y_mm       <= it.y_mm;
    item_if.z_mm       <= it.z_mm;
    item_if.word_index <= it.word_index;
    row_typed          <= typed;
    row_expected       <= exp_res;
    do @(posedge clk_i); while (!item_if.ready);
  endtask

  // Valid stays high across a batch; the caller drops it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  // Drop the item valid, let the monitor book the last transaction, then
  // wait for every pending result.
  task automatic wait_idle();
    item_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Register setting per phase: reset values, two corner settings, then
  // random ones. Every register is written in every phase.
  // --------------------------------------------------------------------------
  task automatic load_phase(input int p);
    int xmin, xmax, ymin, ymax, zl, zh, c, s, ox, oy;
    case (p)
      0: begin
        xmin = -1000; xmax = 1000; ymin = -1000; ymax = 1000;
        zl = -2000; zh = 3000; c = 32767; s = 0; ox = 0; oy = 0;
      end
      1: begin
        // Inverted exclusion removes no point; trig and shifts at
        // their negative and positive limits.
        xmin = 60000; xmax = -60000; ymin = 60000; ymax = -60000;
        zl = -60000; zh = 60000; c = -32768; s = -32768; ox = 32767; oy = -32768;
      end
      2: begin
        // Inverted height window drops every point.
        xmin = -60000; xmax = 60000; ymin = -60000; ymax = 60000;
        zl = 60000; zh = -60000; c = 0; s = 32767; ox = -32768; oy = 32767;
      end
      3: begin
        xmin = rand_between(-3000, 0); xmax = rand_between(0, 3000);
        ymin = rand_between(-3000, 0); ymax = rand_between(0, 3000);
        zl = rand_between(-3000, 0); zh = rand_between(0, 4000);
        c = 32767; s = 0; ox = 0; oy = 0;
      end
      default: begin
        xmin = rand_between(-3000, 0); xmax = rand_between(0, 3000);
        ymin = rand_between(-3000, 0); ymax = rand_between(0, 3000);
        zl = rand_between(-3000, 0); zh = rand_between(0, 4000);
        if ($urandom_range(0, 1) == 0) begin
          c = rand_between(-32768, 32767); s = rand_between(-32768, 32767);
        end else begin
          c = rand_between(28000, 32767); s = rand_between(-16000, 16000);
        end
        ox = rand_between(-3000, 3000); oy = rand_between(-3000, 3000);
      end
    endcase
    write_reg(REG_EXCL_X_MIN, reg_word(xmin));
    write_reg(REG_EXCL_X_MAX, reg_word(xmax));
    write_reg(REG_EXCL_Y_MIN, reg_word(ymin));
    write_reg(REG_EXCL_Y_MAX, reg_word(ymax));
    write_reg(REG_Z_LOW, reg_word(zl));
    write_reg(REG_Z_HIGH, reg_word(zh));
    write_reg(REG_YAW_ROTATION, {16'(s), 16'(c)});
    write_reg(REG_MOUNT_OFFSET, {16'(oy), 16'(ox)});
    // Spare indices must leave every register alone.
    if (p == 0) begin
      for (int i = REG_SPARE_FIRST; i < 2 ** CFG_IDX_W; i++) begin
        write_reg(CFG_IDX_W'(i), $urandom());
      end
    end
    cfg_if.valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result sink: draw a stall per result, with stall-free bursts.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: apply register writes to the shadow, check each result against
  // the oldest expectation, book a prediction for each accepted item, and
  // count cycles in which no channel moves a transaction.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    res_t got, want;
    bit   moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        moved = 1'b1;
        case (cfg_if.index)
          REG_EXCL_X_MIN:   cfg_shadow.excl_x_min = cfg_if.data[REG_W-1:0];
          REG_EXCL_X_MAX:   cfg_shadow.excl_x_max = cfg_if.data[REG_W-1:0];
          REG_EXCL_Y_MIN:   cfg_shadow.excl_y_min = cfg_if.data[REG_W-1:0];
          REG_EXCL_Y_MAX:   cfg_shadow.excl_y_max = cfg_if.data[REG_W-1:0];
          REG_Z_LOW:        cfg_shadow.z_low      = cfg_if.data[REG_W-1:0];
          REG_Z_HIGH:       cfg_shadow.z_high     = cfg_if.data[REG_W-1:0];
          REG_YAW_ROTATION: begin
            cfg_shadow.cos_q15 = cfg_if.data[TRIG_W-1:0];
            cfg_shadow.sin_q15 = cfg_if.data[DATA_W-1:TRIG_W];
          end
          REG_MOUNT_OFFSET: begin
            cfg_shadow.off_x = cfg_if.data[TRIG_W-1:0];
            cfg_shadow.off_y = cfg_if.data[DATA_W-1:TRIG_W];
          end
          default: ;
        endcase
      end

      if (res_if.valid && res_if.ready) begin
        moved          = 1'b1;
        got.kept       = res_if.kept;
        got.in_grid    = res_if.in_grid;
        got.cell_col   = res_if.cell_col;
        got.cell_row   = res_if.cell_row;
        got.word_data  = res_if.word_data;
        got.kept_count = res_if.kept_count;
        if (pending_results.size() == 0) begin
          $error("result transaction with no item pending");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.kept !== want.kept) begin
            $error("kept: expected %0d, actual %0d", want.kept, got.kept);
            fail_count++;
          end
          if (got.in_grid !== want.in_grid) begin
            $error("in_grid: expected %0d, actual %0d", want.in_grid, got.in_grid);
            fail_count++;
          end
          if (got.cell_col !== want.cell_col) begin
            $error("cell_col: expected %0d, actual %0d", want.cell_col, got.cell_col);
            fail_count++;
          end
          if (got.cell_row !== want.cell_row) begin
            $error("cell_row: expected %0d, actual %0d", want.cell_row, got.cell_row);
            fail_count++;
          end
          if (got.word_data !== want.word_data) begin
            $error("word_data: expected %h, actual %h", want.word_data, got.word_data);
            fail_count++;
          end
          if (got.kept_count !== want.kept_count) begin
            $error("kept_count: expected %0d, actual %0d", want.kept_count, got.kept_count);
            fail_count++;
          end
        end
      end

      if (item_if.valid && item_if.ready) begin
        moved = 1'b1;
        // Always advance the shadow; a typed row overrides only the expectation.
        want = predict_marker(item_if.kind, item_if.x_mm, item_if.y_mm, item_if.z_mm,
                              item_if.word_index);
        if (row_typed) want = row_expected;
        pending_results.push_back(want);
      end

      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    marker_item_t it;
    int           roll, zl, zh;
    item_if.valid      <= 1'b0;
    item_if.kind       <= KIND_POINT;
    item_if.x_mm       <= '0;
    item_if.y_mm       <= '0;
    item_if.z_mm       <= '0;
    item_if.word_index <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= '0;
    cfg_if.data        <= '0;
    row_typed          <= 1'b0;
    row_expected       <= '0;
    rst_ni             <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows under the reset setting: exclusion +-1000, height
    // -2000..3000, near-identity yaw, no shift.
    add_row(KIND_READ,   0, 0, 0, 0, 1'b1, 1'b0);               // clean bitmap
    add_row(KIND_FRAME,  0, 0, 0, 0, 1'b1, 1'b0);               // clean counter
    add_row(KIND_UNUSED, 5000, 0, 0, 7, 1'b1, 1'b0);            // unused kind
    add_row(KIND_READ,   0, 0, 0, NUM_WORDS - 1, 1'b1, 1'b0);   // last word
    add_row(KIND_READ,   0, 0, 0, NUM_WORDS, 1'b1, 1'b0);       // past the bitmap
    add_row(KIND_READ,   0, 0, 0, 2 ** IDX_W - 1, 1'b1, 1'b0);  // top index
    add_row(KIND_POINT,  0, 0, 0, 0, 1'b1, 1'b0);               // inside exclusion
    add_row(KIND_POINT,  999, -999, 0, 0, 1'b1, 1'b0);          // just inside
    add_row(KIND_POINT,  1000, 0, 0, 0, 1'b0, 1'b0);            // on upper x edge
    add_row(KIND_POINT,  0, -1000, 0, 0, 1'b0, 1'b0);           // on lower y edge
    add_row(KIND_POINT,  5000, 0, -2000, 0, 1'b0, 1'b0);        // lowest height
    add_row(KIND_POINT,  5000, 0, -2001, 0, 1'b1, 1'b0);
    add_row(KIND_POINT,  5000, 0, 3000, 0, 1'b0, 1'b0);         // highest height
    add_row(KIND_POINT,  5000, 0, 3001, 0, 1'b1, 1'b0);
    add_row(KIND_POINT,  RANGE_MM, -RANGE_MM, 0, 0, 1'b1, 1'b1); // kept, off grid
    add_row(KIND_POINT,  RANGE_MM + 1, 0, 0, 0, 1'b1, 1'b0);     // out of range
    add_row(KIND_POINT,  -131072, 131071, 0, 0, 1'b1, 1'b0);
    add_row(KIND_POINT,  131071, -131072, 131071, 0, 1'b1, 1'b0);
    add_row(KIND_POINT,  -RANGE_MM, -RANGE_MM, -131072, 0, 1'b1, 1'b0);
    add_row(KIND_POINT,  -20020, 5000, 0, 0, 1'b0, 1'b0);       // just below zero
    add_row(KIND_POINT,  19999, 19999, 0, 0, 1'b0, 1'b0);       // last cell
    add_row(KIND_READ,   0, 0, 0, 5006, 1'b0, 1'b0);            // word of (1000, 0)
    add_row(KIND_READ,   0, 0, 0, 5006, 1'b1, 1'b0);            // cleared by the read
    add_row(KIND_FRAME,  0, 0, 0, 0, 1'b0, 1'b0);
    add_row(KIND_FRAME,  0, 0, 0, 0, 1'b1, 1'b0);               // counter restarted
    foreach (stim_rows[i]) send_item(stim_rows[i].item, stim_rows[i].typed,
                                     stim_rows[i].result);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      load_phase(p);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Switch between idling and back-to-back stretches.
        if (n % BURST_SPAN == 0) no_idle = ($urandom_range(0, 3) == 0);
        it.kind       = KIND_POINT;
        it.x_mm       = COORD_W'($urandom());
        it.y_mm       = COORD_W'($urandom());
        it.z_mm       = COORD_W'($urandom());
        it.word_index = IDX_W'($urandom());
        roll = $urandom_range(0, 99);
        if (roll < 68) begin
          // Aim at the grid and the height window so most points get marked.
          it.x_mm = COORD_W'(rand_between(-21000, 21000));
          it.y_mm = COORD_W'(rand_between(-21000, 21000));
          zl = cfg_shadow.z_low;
          zh = cfg_shadow.z_high;
          if (zl <= zh) it.z_mm = COORD_W'(rand_between(zl - 40, zh + 40));
          else it.z_mm = COORD_W'(rand_between(-60000, 60000));
        end else if (roll < 78) begin
          // Keep the fully random point as drawn.
        end else if (roll < 90) begin
          it.kind = KIND_READ;
          if (marked_words.size() > 0 && $urandom_range(0, 2) != 0) begin
            it.word_index = IDX_W'(marked_words[$urandom_range(0, marked_words.size() - 1)]);
          end
        end else if (roll < 98) begin
          it.kind = KIND_FRAME;
        end else begin
          it.kind = KIND_UNUSED;
        end
        send_item(it, 1'b0, '0);
      end
    end

    no_idle = 1'b0;
    wait_idle();
    // Catch any stray result after the last expectation.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/occ_pkg.sv
design/occ_if.sv
design/occ_ram.sv
design/occ_xform.sv
design/occ_map.sv
design/point_cloud_occupancy_marker_unit.sv
design/occ_checker.sv
sim/point_cloud_occupancy_marker_unit_tb.sv
